>>> rtl/pkf_pkg.sv
// Shared types, constants and helpers of the packet port and keyword filter.
package pkf_pkg;

    localparam int CASE_FOLD_WINDOW = 2048;
    localparam int MAX_PACKET_BYTES = 65535;
    localparam int COUNT_W          = 16;
    localparam int CELLS            = 6;

    localparam logic [55:0] KEY_UPPER_WORD = 56'h424C4F434B4D45;
    localparam logic [55:0] KEY_LOWER_WORD = 56'h626C6F636B6D65;

    localparam logic [3:0]  IP_VERSION     = 4'd4;
    localparam logic [7:0]  PROTO_TCP      = 8'd6;
    localparam logic [5:0]  MIN_IP_HDR     = 6'd20;
    localparam logic [15:0] TCP_HDR_BYTES  = 16'd20;
    localparam logic [15:0] PROTO_POS      = 16'd9;
    localparam logic [16:0] RULE_NONE      = 17'd0;
    localparam logic [16:0] RULE_PORT_BASE = 17'd1000;
    localparam logic [16:0] RULE_KEYWORD   = 17'd2001;

    typedef enum logic [1:0] {
        CFG_DROP_PORT      = 2'd0,
        CFG_KEYWORD_ENABLE = 2'd1,
        CFG_KEYWORD_CI     = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic shift;
        logic clear;
    } cell_ctrl_t;

    typedef struct packed {
        logic exact;
        logic folded;
    } hit_t;

    typedef struct packed {
        logic [16:0] rule_id;
        logic        drop;
    } out_item_t;

    function automatic logic [7:0] fold_char(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A)
        begin
            r = c + 8'h20;
        end
        return r;
    endfunction

endpackage

>>> rtl/pkf_cell.sv
// One byte cell of the keyword window: holds a byte, shifts it on, compares it.
module pkf_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  pkf_pkg::cell_ctrl_t ctrl,
    input  logic [7:0]         din,
    input  logic [7:0]         key_upper,
    input  logic [7:0]         key_lower,
    output logic [7:0]         dout,
    output pkf_pkg::hit_t      hit
);
    import pkf_pkg::*;

    logic [7:0] byte_reg;
    logic [7:0] byte_next;

    always_comb
    begin
        byte_next = byte_reg;
        if (ctrl.shift)
        begin
            byte_next = ctrl.clear ? 8'd0 : din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_reg <= 8'd0;
        end
        else
        begin
            byte_reg <= byte_next;
        end
    end

    assign dout       = byte_reg;
    assign hit.exact  = (byte_reg == key_upper);
    assign hit.folded = (fold_char(byte_reg) == key_lower);

endmodule

>>> rtl/pkf_outbuf.sv
// Two-entry verdict buffer: output register plus skid entry.
module pkf_outbuf (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  pkf_pkg::out_item_t  push_item,
    output logic                room,
    output logic                out_valid,
    input  logic                out_ready,
    output pkf_pkg::out_item_t  out_item
);
    import pkf_pkg::*;

    logic      head_valid_reg;
    logic      head_valid_next;
    out_item_t head_reg;
    out_item_t head_next;
    logic      skid_valid_reg;
    logic      skid_valid_next;
    out_item_t skid_reg;
    out_item_t skid_next;
    logic      pop;

    assign pop = head_valid_reg & out_ready;

    always_comb
    begin
        head_valid_next = head_valid_reg;
        head_next       = head_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                head_next = skid_reg;
                if (push)
                begin
                    skid_next = push_item;
                end
                else
                begin
                    skid_valid_next = 1'b0;
                end
            end
            else if (push)
            begin
                head_next = push_item;
            end
            else
            begin
                head_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!head_valid_reg)
            begin
                head_next       = push_item;
                head_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = push_item;
                skid_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            head_valid_reg <= head_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        skid_reg <= skid_next;
    end

    assign room      = ~skid_valid_reg;
    assign out_valid = head_valid_reg;
    assign out_item  = head_reg;

endmodule

>>> rtl/packet_port_and_keyword_filter.sv
// Top level of the IPv4 TCP port and payload keyword filter.
//
//  group  | dir | handshake          | payload
//  -------+-----+--------------------+--------------------------------------
//  s_     | in  | s_tvalid/s_tready  | s_tdata[7:0] packet_byte, s_tlast last_byte
//  m_     | out | m_tvalid/m_tready  | m_tdata[0] drop, [17:1] rule_id
//  cfg_   | in  | cfg_valid/cfg_ready| cfg_index, cfg_data
//
//  One byte per cycle while s_tready is high; the last byte pushes its verdict.
//  Keyword search runs through a row of six byte cells plus a compare on the new byte.
//  Reset clears the packet state and loads drop_port 0, keyword_enable 1, case fold 0.
//  A two-entry verdict buffer lets bytes flow while one verdict waits; input stalls
//  only when two verdicts wait.
module packet_port_and_keyword_filter (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] packet_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // [0] drop, [17:1] rule_id, [23:18] zero
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import pkf_pkg::*;

    logic [15:0] drop_port_reg;
    logic        keyword_enable_reg;
    logic        keyword_ci_reg;

    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic               version_ok_reg;
    logic               version_ok_next;
    logic [5:0]         hdr_bytes_reg;
    logic [5:0]         hdr_bytes_next;
    logic               is_tcp_reg;
    logic               is_tcp_next;
    logic [15:0]        dest_port_reg;
    logic [15:0]        dest_port_next;
    logic               found_reg;
    logic               found_next;

    logic               accept;
    logic               last_accept;
    logic [15:0]        hdr16;
    logic               all_exact;
    logic               all_folded;
    logic               in_window;
    logic               match;
    logic               hdr_ok;
    logic               port_hit;
    out_item_t          verdict;
    out_item_t          out_item;
    logic               buf_room;
    cell_ctrl_t         ctrl;
    logic [7:0]         cell_in   [CELLS];
    logic [7:0]         cell_out  [CELLS];
    hit_t               cell_hit  [CELLS];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drop_port_reg      <= 16'd0;
            keyword_enable_reg <= 1'b1;
            keyword_ci_reg     <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_DROP_PORT:      drop_port_reg      <= cfg_data;
                CFG_KEYWORD_ENABLE: keyword_enable_reg <= cfg_data[0];
                CFG_KEYWORD_CI:     keyword_ci_reg     <= cfg_data[0];
                default:            ;
            endcase
        end
    end

    assign accept      = s_tvalid & s_tready;
    assign last_accept = accept & s_tlast;
    assign ctrl.shift  = accept;
    assign ctrl.clear  = s_tlast;

    genvar g;
    generate
        for (g = 0; g < CELLS; g++)
        begin : g_cell
            if (g == 0)
            begin : g_head
                assign cell_in[g] = s_tdata;
            end
            else
            begin : g_link
                assign cell_in[g] = cell_out[g-1];
            end
            pkf_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (ctrl),
                .din       (cell_in[g]),
                .key_upper (KEY_UPPER_WORD[8*(g+1) +: 8]),
                .key_lower (KEY_LOWER_WORD[8*(g+1) +: 8]),
                .dout      (cell_out[g]),
                .hit       (cell_hit[g])
            );
        end
    endgenerate

    always_comb
    begin
        all_exact  = (s_tdata == KEY_UPPER_WORD[7:0]);
        all_folded = (fold_char(s_tdata) == KEY_LOWER_WORD[7:0]);
        for (int i = 0; i < CELLS; i++)
        begin
            all_exact  = all_exact  & cell_hit[i].exact;
            all_folded = all_folded & cell_hit[i].folded;
        end
    end

    always_comb
    begin
        version_ok_next = version_ok_reg;
        hdr_bytes_next  = hdr_bytes_reg;
        if (count_reg == '0)
        begin
            version_ok_next = (s_tdata[7:4] == IP_VERSION);
            hdr_bytes_next  = {s_tdata[3:0], 2'b00};
        end
        hdr16       = {10'd0, hdr_bytes_next};
        is_tcp_next = (count_reg == PROTO_POS) ? (s_tdata == PROTO_TCP) : is_tcp_reg;
        dest_port_next = dest_port_reg;
        if (count_reg == hdr16 + 16'd2)
        begin
            dest_port_next[15:8] = s_tdata;
        end
        if (count_reg == hdr16 + 16'd3)
        begin
            dest_port_next[7:0] = s_tdata;
        end
        in_window  = (count_reg < COUNT_W'(CASE_FOLD_WINDOW));
        match      = keyword_ci_reg ? (all_folded & in_window) : all_exact;
        found_next = found_reg | match;
        count_next = (count_reg == COUNT_W'(MAX_PACKET_BYTES)) ? count_reg
                                                               : count_reg + 1'b1;
    end

    always_comb
    begin
        hdr_ok   = (count_next >= 16'(MIN_IP_HDR)) && version_ok_next
                   && (hdr_bytes_next >= MIN_IP_HDR) && (hdr16 <= count_next);
        port_hit = is_tcp_next && (count_next >= hdr16 + TCP_HDR_BYTES)
                   && (drop_port_reg != 16'd0) && (dest_port_next == drop_port_reg);
        verdict.drop    = 1'b0;
        verdict.rule_id = RULE_NONE;
        if (hdr_ok)
        begin
            priority if (port_hit)
            begin
                verdict.drop    = 1'b1;
                verdict.rule_id = RULE_PORT_BASE + {1'b0, dest_port_next};
            end
            else if (keyword_enable_reg && found_next)
            begin
                verdict.drop    = 1'b1;
                verdict.rule_id = RULE_KEYWORD;
            end
            else
            begin
                verdict.drop    = 1'b0;
                verdict.rule_id = RULE_NONE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            version_ok_reg <= 1'b0;
            hdr_bytes_reg  <= 6'd0;
            is_tcp_reg     <= 1'b0;
            dest_port_reg  <= 16'd0;
            found_reg      <= 1'b0;
        end
        else if (accept)
        begin
            if (s_tlast)
            begin
                count_reg      <= '0;
                version_ok_reg <= 1'b0;
                hdr_bytes_reg  <= 6'd0;
                is_tcp_reg     <= 1'b0;
                dest_port_reg  <= 16'd0;
                found_reg      <= 1'b0;
            end
            else
            begin
                count_reg      <= count_next;
                version_ok_reg <= version_ok_next;
                hdr_bytes_reg  <= hdr_bytes_next;
                is_tcp_reg     <= is_tcp_next;
                dest_port_reg  <= dest_port_next;
                found_reg      <= found_next;
            end
        end
    end

    pkf_outbuf u_outbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (last_accept),
        .push_item (verdict),
        .room      (buf_room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_item  (out_item)
    );

    assign s_tready = buf_room;
    assign m_tdata  = {6'd0, out_item.rule_id, out_item.drop};

    a_stall_needs_waiting_verdict: assert property (
        @(posedge clk) disable iff (!rst_n) !s_tready |-> m_tvalid)
        else $error("input stalled with no verdict waiting");

    a_pass_has_no_rule: assert property (
        @(posedge clk) disable iff (!rst_n) (m_tvalid && !m_tdata[0]) |-> (m_tdata[17:1] == 17'd0))
        else $error("pass verdict carries a rule");

    a_drop_has_rule: assert property (
        @(posedge clk) disable iff (!rst_n) (m_tvalid && m_tdata[0]) |-> (m_tdata[17:1] != 17'd0))
        else $error("drop verdict without rule");

    a_clear_after_last: assert property (
        @(posedge clk) disable iff (!rst_n) last_accept |=> (count_reg == '0 && !found_reg))
        else $error("packet state not cleared after last byte");

endmodule
